// File: src/pso_pkg.sv
// Shared types, codes and defaults of the tagged operand stack.
// No dependencies; pso_if, pso_mod, the top level and the checker import this package.
package pso_pkg;

    localparam int unsigned STACK_DEPTH_DEF = 64;
    localparam int unsigned CMD_W = 4;
    localparam int unsigned TAG_W = 3;
    localparam int unsigned VAL_W = 64;
    localparam int unsigned ST_W  = 3;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 4'd0;
    localparam logic [CMD_W-1:0] CMD_DUP    = 4'd1;
    localparam logic [CMD_W-1:0] CMD_EXCH   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_POP    = 4'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_MARK   = 4'd5;
    localparam logic [CMD_W-1:0] CMD_COUNT  = 4'd6;
    localparam logic [CMD_W-1:0] CMD_CTMARK = 4'd7;
    localparam logic [CMD_W-1:0] CMD_CLMARK = 4'd8;
    localparam logic [CMD_W-1:0] CMD_INDEX  = 4'd9;
    localparam logic [CMD_W-1:0] CMD_COPY   = 4'd10;
    localparam logic [CMD_W-1:0] CMD_ROLL   = 4'd11;

    localparam logic [ST_W-1:0] ST_OK     = 3'd0;
    localparam logic [ST_W-1:0] ST_UNDER  = 3'd1;
    localparam logic [ST_W-1:0] ST_OVER   = 3'd2;
    localparam logic [ST_W-1:0] ST_TYPE   = 3'd3;
    localparam logic [ST_W-1:0] ST_RANGE  = 3'd4;
    localparam logic [ST_W-1:0] ST_NOMARK = 3'd5;

    localparam logic [TAG_W-1:0] TAG_INT  = 3'd0;
    localparam logic [TAG_W-1:0] TAG_MARK = 3'd3;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [VAL_W-1:0] value;
    } t_word;

endpackage

// File: src/pso_if.sv
// Handshake channels of the operand stack: command words in, result words out.
// Depends on pso_pkg for field widths.
interface pso_cmd_if import pso_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [TAG_W-1:0] push_tag;
    logic [VAL_W-1:0] push_value;

    modport source(output valid, command, push_tag, push_value, input ready);
    modport sink(input valid, command, push_tag, push_value, output ready);
endinterface

interface pso_res_if import pso_pkg::*; #(parameter int unsigned DEPTH_W = 7) ();
    logic               valid;
    logic               ready;
    logic [ST_W-1:0]    status;
    logic [DEPTH_W-1:0] depth;
    logic [TAG_W-1:0]   top_tag;
    logic [VAL_W-1:0]   top_value;

    modport source(output valid, status, depth, top_tag, top_value, input ready);
    modport sink(input valid, status, depth, top_tag, top_value, output ready);
endinterface

// File: src/pso_ram.sv
// Single-port-write, single-port-read synchronous memory, registered read data.
// Depends on nothing; holds stack entries and the roll scratch area.
module pso_ram #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 67
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wa,
    input  logic [WIDTH-1:0]         i_wd,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_ra,
    output logic [WIDTH-1:0]         o_rd
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wa] <= i_wd;
        end
        if (i_re) begin
            r_rd <= mem[i_ra];
        end
    end

    assign o_rd = r_rd;
endmodule

// File: src/pso_mod.sv
// Bit-serial remainder unit: one dividend bit per cycle against a narrow divisor.
// Depends on pso_pkg for the value width.
module pso_mod import pso_pkg::*; #(
    parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [VAL_W-1:0]                 i_dividend,
    input  logic [$clog2(STACK_DEPTH+1)-1:0] i_divisor,
    output logic                             o_done,
    output logic [$clog2(STACK_DEPTH+1)-1:0] o_rem
);
    localparam int unsigned FW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned CW = $clog2(VAL_W);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [VAL_W-1:0] r_dvd, n_dvd;
    logic [FW-1:0] r_dvs, n_dvs;
    logic [FW-1:0] r_rem, n_rem;
    logic [FW:0]   trial;
    logic [FW:0]   diff;

    always_comb begin
        trial  = {r_rem, r_dvd[VAL_W-1]};
        diff   = trial - {1'b0, r_dvs};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dvd  = i_dividend;
            n_dvs  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            n_rem = (trial >= {1'b0, r_dvs}) ? diff[FW-1:0] : trial[FW-1:0];
            n_dvd = {r_dvd[VAL_W-2:0], 1'b0};
            n_cnt = r_cnt + CW'(1);
            if (r_cnt == CW'(VAL_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

// File: src/postscript_operand_stack.sv
// Channel  Dir  Handshake      Word
// i_cmd    in   valid/ready    command, push_tag, push_value
// o_res    out  valid/ready    status, depth, top_tag, top_value
//
// Commands run one at a time; no new command is accepted until the last one has left S_DONE.
// Push, dup, mark, count, clear and unknown commands finish in S_EXEC; pop, exch, index,
// counttomark and cleartomark read the memory, the scans walking the m words above the marker;
// copy moves its n entries, and roll runs the 64-step remainder unit and makes two passes
// through the scratch memory when n is not zero.
// Synchronous active-low reset clears depth and the top word; memory keeps contents.
// A stalled result word keeps the command in its final state, S_DONE, and holds off the next command.
// Depends on pso_pkg, pso_if, pso_ram, pso_mod.
module postscript_operand_stack import pso_pkg::*; #(
    parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pso_cmd_if.sink     i_cmd,
    pso_res_if.source   o_res
);
    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned FW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned WW = TAG_W + VAL_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_EXEC    = 4'd1;
    localparam logic [3:0] S_EXCH    = 4'd2;
    localparam logic [3:0] S_EXCH2   = 4'd3;
    localparam logic [3:0] S_SCAN    = 4'd4;
    localparam logic [3:0] S_SCANW   = 4'd5;
    localparam logic [3:0] S_INDEXW  = 4'd6;
    localparam logic [3:0] S_ROLLW   = 4'd7;
    localparam logic [3:0] S_MOD     = 4'd8;
    localparam logic [3:0] S_MOVE    = 4'd9;
    localparam logic [3:0] S_RELOAD  = 4'd10;
    localparam logic [3:0] S_RELOADW = 4'd11;
    localparam logic [3:0] S_DONE    = 4'd12;

    logic [3:0]       r_state, n_state;
    logic [CMD_W-1:0] r_cmd, n_cmd;
    t_word            r_push, n_push;
    logic [FW-1:0]    r_fill, n_fill;
    t_word            r_top, n_top;
    logic [ST_W-1:0]  r_status, n_status;
    logic [FW-1:0]    r_i, n_i;
    logic [FW-1:0]    r_n, n_n;
    logic [FW-1:0]    r_base, n_base;
    logic [FW-1:0]    r_d, n_d;
    logic             r_pass, n_pass;
    logic             r_pend, n_pend;
    logic [FW-1:0]    r_wa, n_wa;
    logic             r_neg, n_neg;
    logic             r_ov, n_ov;
    logic [ST_W-1:0]  r_ost, n_ost;
    logic [FW-1:0]    r_odep, n_odep;
    t_word            r_oword, n_oword;

    logic          m_we, m_re, t_we, t_re;
    logic [FW-1:0] m_wa, m_ra, t_wa, t_ra;
    t_word         m_wd, t_wd, m_rd, t_rd;
    logic [WW-1:0] m_rdv, t_rdv;

    logic              mod_start, mod_done;
    logic [FW-1:0]     mod_rem;
    logic [VAL_W-1:0]  mod_dvd;

    logic [FW-1:0] fm1, fm2, arg_n, rl_n, shift;
    logic          full, is_roll, cp_over;
    t_word         push_w;
    logic [FW:0]   cp_sum;

    pso_ram #(.DEPTH(STACK_DEPTH), .WIDTH(WW)) u_stack_ram (
        .i_clk(i_clk), .i_we(m_we), .i_wa(m_wa[AW-1:0]), .i_wd(m_wd),
        .i_re(m_re), .i_ra(m_ra[AW-1:0]), .o_rd(m_rdv)
    );

    pso_ram #(.DEPTH(STACK_DEPTH), .WIDTH(WW)) u_scratch_ram (
        .i_clk(i_clk), .i_we(t_we), .i_wa(t_wa[AW-1:0]), .i_wd(t_wd),
        .i_re(t_re), .i_ra(t_ra[AW-1:0]), .o_rd(t_rdv)
    );

    pso_mod #(.STACK_DEPTH(STACK_DEPTH)) u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mod_start),
        .i_dividend(mod_dvd), .i_divisor(rl_n), .o_done(mod_done), .o_rem(mod_rem)
    );

    assign m_rd    = m_rdv;
    assign t_rd    = t_rdv;
    assign fm1     = r_fill - FW'(1);
    assign fm2     = r_fill - FW'(2);
    assign full    = r_fill >= FW'(STACK_DEPTH);
    assign is_roll = r_cmd == CMD_ROLL;
    assign arg_n   = r_top.value[FW-1:0];
    assign rl_n    = m_rd.value[FW-1:0];
    assign cp_sum  = {1'b0, fm1} + {1'b0, arg_n};
    assign cp_over = cp_sum > (FW+1)'(STACK_DEPTH);
    assign mod_dvd = r_top.value[VAL_W-1] ? (VAL_W'(0) - r_top.value) : r_top.value;
    assign shift   = r_neg ? ((mod_rem == '0) ? '0 : r_n - mod_rem) : mod_rem;

    always_comb begin
        case (r_cmd)
            CMD_DUP:   push_w = r_top;
            CMD_MARK:  push_w = '{tag: TAG_MARK, value: '0};
            CMD_COUNT: push_w = '{tag: TAG_INT, value: VAL_W'(r_fill)};
            default:   push_w = r_push;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_push   = r_push;
        n_fill   = r_fill;
        n_top    = r_top;
        n_status = r_status;
        n_i      = r_i;
        n_n      = r_n;
        n_base   = r_base;
        n_d      = r_d;
        n_pass   = r_pass;
        n_pend   = r_pend;
        n_wa     = r_wa;
        n_neg    = r_neg;
        n_ov     = r_ov & ~o_res.ready;
        n_ost    = r_ost;
        n_odep   = r_odep;
        n_oword  = r_oword;
        m_we = 1'b0; m_wa = '0; m_wd = r_top; m_re = 1'b0; m_ra = '0;
        t_we = 1'b0; t_wa = '0; t_wd = m_rd;  t_re = 1'b0; t_ra = '0;
        mod_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd    = i_cmd.command;
                    n_push   = '{tag: i_cmd.push_tag, value: i_cmd.push_value};
                    n_status = ST_OK;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_cmd)
                    CMD_PUSH, CMD_DUP, CMD_MARK, CMD_COUNT: begin
                        if (r_cmd == CMD_DUP && r_fill == '0) begin
                            n_status = ST_UNDER;
                        end else if (full) begin
                            n_status = ST_OVER;
                        end else begin
                            m_we   = 1'b1;
                            m_wa   = r_fill;
                            m_wd   = push_w;
                            n_top  = push_w;
                            n_fill = r_fill + FW'(1);
                        end
                    end
                    CMD_EXCH: begin
                        if (r_fill < FW'(2)) begin
                            n_status = ST_UNDER;
                        end else begin
                            m_re    = 1'b1;
                            m_ra    = fm2;
                            n_state = S_EXCH;
                        end
                    end
                    CMD_POP: begin
                        if (r_fill == '0) begin
                            n_status = ST_UNDER;
                        end else begin
                            n_fill  = fm1;
                            n_state = S_RELOAD;
                        end
                    end
                    CMD_CLEAR: begin
                        n_fill = '0;
                        n_top  = '0;
                    end
                    CMD_CTMARK, CMD_CLMARK: begin
                        n_i     = '0;
                        n_state = S_SCAN;
                    end
                    CMD_INDEX, CMD_COPY: begin
                        if (r_fill == '0) begin
                            n_status = ST_UNDER;
                        end else if (r_top.tag != TAG_INT) begin
                            n_status = ST_TYPE;
                        end else if (r_top.value[VAL_W-1]) begin
                            n_status = ST_RANGE;
                        end else if (r_cmd == CMD_INDEX) begin
                            if (r_top.value >= VAL_W'(fm1)) begin
                                n_status = ST_UNDER;
                            end else begin
                                m_re    = 1'b1;
                                m_ra    = fm2 - arg_n;
                                n_state = S_INDEXW;
                            end
                        end else if (r_top.value > VAL_W'(fm1)) begin
                            n_status = ST_UNDER;
                        end else if (cp_over) begin
                            n_status = ST_OVER;
                        end else begin
                            n_fill  = fm1;
                            n_base  = fm1 - arg_n;
                            n_n     = arg_n;
                            n_i     = '0;
                            n_pend  = 1'b0;
                            n_pass  = 1'b0;
                            n_state = S_MOVE;
                        end
                    end
                    CMD_ROLL: begin
                        if (r_fill < FW'(2)) begin
                            n_status = ST_UNDER;
                        end else begin
                            m_re    = 1'b1;
                            m_ra    = fm2;
                            n_state = S_ROLLW;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_EXCH: begin
                m_we    = 1'b1;
                m_wa    = fm2;
                m_wd    = r_top;
                n_top   = m_rd;
                n_state = S_EXCH2;
            end
            S_EXCH2: begin
                m_we    = 1'b1;
                m_wa    = fm1;
                m_wd    = r_top;
                n_state = S_DONE;
            end
            S_SCAN: begin
                if (r_i == r_fill) begin
                    n_status = ST_NOMARK;
                    n_state  = S_DONE;
                end else begin
                    m_re    = 1'b1;
                    m_ra    = fm1 - r_i;
                    n_state = S_SCANW;
                end
            end
            S_SCANW: begin
                if (m_rd.tag == TAG_MARK) begin
                    if (r_cmd == CMD_CTMARK) begin
                        n_state = S_DONE;
                        if (full) begin
                            n_status = ST_OVER;
                        end else begin
                            m_we   = 1'b1;
                            m_wa   = r_fill;
                            m_wd   = '{tag: TAG_INT, value: VAL_W'(r_i)};
                            n_top  = '{tag: TAG_INT, value: VAL_W'(r_i)};
                            n_fill = r_fill + FW'(1);
                        end
                    end else begin
                        n_fill  = fm1 - r_i;
                        n_state = S_RELOAD;
                    end
                end else begin
                    n_i     = r_i + FW'(1);
                    n_state = S_SCAN;
                end
            end
            S_INDEXW: begin
                m_we    = 1'b1;
                m_wa    = fm1;
                m_wd    = m_rd;
                n_top   = m_rd;
                n_state = S_DONE;
            end
            S_ROLLW: begin
                n_state = S_DONE;
                if (r_top.tag != TAG_INT || m_rd.tag != TAG_INT) begin
                    n_status = ST_TYPE;
                end else if (m_rd.value[VAL_W-1]) begin
                    n_status = ST_RANGE;
                end else if (m_rd.value > VAL_W'(fm2)) begin
                    n_status = ST_UNDER;
                end else begin
                    n_fill = fm2;
                    n_n    = rl_n;
                    n_base = fm2 - rl_n;
                    n_neg  = r_top.value[VAL_W-1];
                    if (rl_n == '0) begin
                        n_state = S_RELOAD;
                    end else begin
                        mod_start = 1'b1;
                        n_state   = S_MOD;
                    end
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    n_d     = shift;
                    n_i     = '0;
                    n_pend  = 1'b0;
                    n_pass  = 1'b0;
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                if (r_pend) begin
                    if (is_roll && !r_pass) begin
                        t_we = 1'b1;
                        t_wa = r_wa;
                        t_wd = m_rd;
                    end else begin
                        m_we = 1'b1;
                        m_wa = r_wa;
                        m_wd = (is_roll) ? t_rd : m_rd;
                    end
                end
                if (r_i != r_n) begin
                    if (is_roll && r_pass) begin
                        t_re = 1'b1;
                        t_ra = r_i;
                        n_wa = r_base + r_i;
                    end else begin
                        m_re = 1'b1;
                        m_ra = r_base + r_i;
                        n_wa = is_roll ? r_d : r_fill + r_i;
                    end
                    n_d    = (r_d + FW'(1) == r_n) ? '0 : r_d + FW'(1);
                    n_pend = 1'b1;
                    n_i    = r_i + FW'(1);
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        if (is_roll && !r_pass) begin
                            n_pass = 1'b1;
                            n_i    = '0;
                        end else begin
                            if (!is_roll) begin
                                n_fill = r_fill + r_n;
                            end
                            n_state = S_RELOAD;
                        end
                    end
                end
            end
            S_RELOAD: begin
                if (r_fill == '0) begin
                    n_top   = '0;
                    n_state = S_DONE;
                end else begin
                    m_re    = 1'b1;
                    m_ra    = fm1;
                    n_state = S_RELOADW;
                end
            end
            S_RELOADW: begin
                n_top   = m_rd;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || o_res.ready) begin
                    n_ov    = 1'b1;
                    n_ost   = r_status;
                    n_odep  = r_fill;
                    n_oword = r_top;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_top   <= '0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_top   <= n_top;
            r_pend  <= n_pend;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_push   <= n_push;
        r_status <= n_status;
        r_i      <= n_i;
        r_n      <= n_n;
        r_base   <= n_base;
        r_d      <= n_d;
        r_pass   <= n_pass;
        r_wa     <= n_wa;
        r_neg    <= n_neg;
        r_ost    <= n_ost;
        r_odep   <= n_odep;
        r_oword  <= n_oword;
    end

    assign i_cmd.ready     = r_state == S_IDLE;
    assign o_res.valid     = r_ov;
    assign o_res.status    = r_ost;
    assign o_res.depth     = r_odep;
    assign o_res.top_tag   = r_oword.tag;
    assign o_res.top_value = r_oword.value;
endmodule

// File: src/pso_chk.sv
// Port-level checker for the operand stack, bound to the top level.
// Depends on pso_pkg and postscript_operand_stack.
module pso_chk import pso_pkg::*; #(
    parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [ST_W-1:0]                  i_status,
    input logic [$clog2(STACK_DEPTH+1)-1:0] i_depth,
    input logic [TAG_W-1:0]                 i_tag,
    input logic [VAL_W-1:0]                 i_value
);
    localparam int unsigned FW = $clog2(STACK_DEPTH + 1);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable({i_status, i_depth, i_tag, i_value}))
        else $error("result word changed while stalled");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_depth <= FW'(STACK_DEPTH))
        else $error("depth beyond stack size");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_depth == '0 |-> i_tag == '0 && i_value == '0)
        else $error("empty stack shows a top word");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_status <= ST_NOMARK)
        else $error("status code out of range");

    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second command word taken while busy");
endmodule

bind postscript_operand_stack pso_chk #(.STACK_DEPTH(STACK_DEPTH)) u_pso_chk (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_valid(i_cmd.valid),
    .i_in_ready(i_cmd.ready),
    .i_out_valid(o_res.valid),
    .i_out_ready(o_res.ready),
    .i_status(o_res.status),
    .i_depth(o_res.depth),
    .i_tag(o_res.top_tag),
    .i_value(o_res.top_value)
);
